### src/seq_window_ack_beacon_gateway_defines.svh
// Assertion macros shared by the gateway checker
`ifndef SEQ_WINDOW_ACK_BEACON_GATEWAY_DEFINES_SVH
`define SEQ_WINDOW_ACK_BEACON_GATEWAY_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define SWAB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SWAB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/swab_pkg.sv
// Types and constants for the acknowledgement-window beacon gateway
`timescale 1ns / 1ps
package swab_pkg;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_PACKET = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_BEACON_INTERVAL = 2'd0,
      CSR_WINDOW_SPAN     = 2'd1,
      CSR_IDLE_LIMIT      = 2'd2
   } csr_index_type;

   localparam logic KIND_BEACON = 1'b0;
   localparam logic KIND_ACK    = 1'b1;

   localparam logic [7:0]  PAYLOAD_BYTES         = 8'd12;
   localparam logic [15:0] BEACON_INTERVAL_RESET = 16'd1000;
   localparam logic [7:0]  WINDOW_SPAN_RESET     = 8'd10;
   localparam logic [15:0] IDLE_LIMIT_RESET      = 16'd800;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  payload_length;
      logic [15:0] seq_number;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] received_count;
      logic       last;
   } rsp_type;

endpackage

### src/seq_window_ack_beacon_gateway.sv
// Acknowledgement-window gateway with periodic beacon
// Usage:
//   req channel (req_valid / req_stall / req_data) carries ticks, packets
//   and window clears. rsp channel (rsp_valid / rsp_stall / rsp_data)
//   returns beacon and acknowledgement requests, zero to two per item,
//   with last set on the final one of each item.
//   csr_we / csr_index / csr_wdata write the beacon interval, window span
//   and idle limit; write only while the block is idle.
// Timing:
//   An item is decoded and its results written to a four-entry output
//   queue in the cycle it is accepted; results reach rsp_* from the
//   registered queue. One item is accepted per cycle while the queue
//   has room for two results, so the rate is one item per cycle while the
//   receiver keeps up, falling only while items causing two results arrive
//   back to back, since the queue has a single read port.
// Reset: counters, window and queue clear; registers return to 1000,
//   10 and 800. When the receiver stalls, the head result holds and
//   req_stall rises once fewer than two queue slots are free.
`timescale 1ns / 1ps
module seq_window_ack_beacon_gateway (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  swab_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output swab_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import swab_pkg::*;

   logic [15:0] beacon_interval_ff;
   logic [7:0]  window_span_ff;
   logic [15:0] idle_limit_ff;

   logic [15:0] tsb_ff, tsb_in;
   logic [15:0] tsp_ff, tsp_in;
   logic [15:0] start_ff, start_in;
   logic [7:0]  count_ff, count_in;

   rsp_type          queue_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] fill_ff;

   logic        accept, pop;
   logic [1:0]  n_res;
   rsp_type     res0, res1;
   logic [15:0] tsb_inc, tsp_inc, span, start_new;
   logic [16:0] span_plus;
   logic [7:0]  count_inc;
   logic        beacon, ack_idle;

   assign req_stall = fill_ff > CNT_W'(FIFO_DEPTH - 2);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = fill_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      tsb_inc   = (tsb_ff == 16'hFFFF) ? tsb_ff : tsb_ff + 16'd1;
      tsp_inc   = (tsp_ff == 16'hFFFF) ? tsp_ff : tsp_ff + 16'd1;
      beacon    = tsb_inc >= beacon_interval_ff;
      ack_idle  = (count_ff != 8'd0) && (tsp_inc >= idle_limit_ff);
      start_new = (count_ff == 8'd0) ? req_data.seq_number : start_ff;
      count_inc = (count_ff == 8'hFF) ? count_ff : count_ff + 8'd1;
      span      = req_data.seq_number - start_new;
      span_plus = {1'b0, span} + 17'd1;

      tsb_in   = tsb_ff;
      tsp_in   = tsp_ff;
      start_in = start_ff;
      count_in = count_ff;
      n_res    = 2'd0;
      res0     = '{kind: KIND_BEACON, received_count: 8'd0, last: 1'b1};
      res1     = '{kind: KIND_ACK, received_count: count_ff, last: 1'b1};

      case (req_data.operation)
         OP_TICK: begin
            tsb_in = beacon ? 16'd0 : tsb_inc;
            tsp_in = tsp_inc;
            if (ack_idle) begin
               count_in = 8'd0;
            end
            if (beacon && ack_idle) begin
               res0.last = 1'b0;
               n_res     = 2'd2;
            end else if (beacon) begin
               n_res = 2'd1;
            end else if (ack_idle) begin
               res0  = '{kind: KIND_ACK, received_count: count_ff, last: 1'b1};
               n_res = 2'd1;
            end
         end
         OP_PACKET: begin
            if (req_data.payload_length == PAYLOAD_BYTES) begin
               start_in = start_new;
               tsp_in   = 16'd0;
               count_in = count_inc;
               if (span_plus >= {9'd0, window_span_ff}) begin
                  res0     = '{kind: KIND_ACK, received_count: count_inc, last: 1'b1};
                  n_res    = 2'd1;
                  count_in = 8'd0;
               end
            end
         end
         OP_CLEAR: begin
            count_in = 8'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beacon_interval_ff <= BEACON_INTERVAL_RESET;
         window_span_ff     <= WINDOW_SPAN_RESET;
         idle_limit_ff      <= IDLE_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BEACON_INTERVAL: beacon_interval_ff <= csr_wdata;
            CSR_WINDOW_SPAN:     window_span_ff     <= csr_wdata[7:0];
            CSR_IDLE_LIMIT:      idle_limit_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tsb_ff   <= '0;
         tsp_ff   <= '0;
         start_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         tsb_ff   <= tsb_in;
         tsp_ff   <= tsp_in;
         start_ff <= start_in;
         count_ff <= count_in;
      end
   end

   // results of one transfer go in together, head leaves on each output transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + (accept ? PTR_W'(n_res) : PTR_W'(0));
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         fill_ff   <= fill_ff + (accept ? CNT_W'(n_res) : CNT_W'(0)) - CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (accept && n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (accept && n_res == 2'd2) begin
         queue_ff[wr_ptr_ff + PTR_W'(1)] <= res1;
      end
   end

endmodule

### src/swab_checker.sv
// Port-level checker for the gateway, bound to the top level
`timescale 1ns / 1ps
`include "seq_window_ack_beacon_gateway_defines.svh"
module swab_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input swab_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input swab_pkg::rsp_type rsp_data,
   input logic              csr_we,
   input logic [1:0]        csr_index,
   input logic [15:0]       csr_wdata
);
   import swab_pkg::*;

   logic unused_ok;
   assign unused_ok = req_valid ^ (^req_data) ^ csr_we ^ (^csr_index) ^ (^csr_wdata);

   `SWAB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
   `SWAB_ASSERT_IMP(a_beacon_zero, clock, reset, rsp_valid && rsp_data.kind == KIND_BEACON, rsp_data.received_count == 8'd0, "beacon with non-zero count")
   `SWAB_ASSERT_IMP(a_ack_count, clock, reset, rsp_valid && rsp_data.kind == KIND_ACK, rsp_data.received_count != 8'd0, "acknowledgement of an empty window")
   `SWAB_ASSERT_IMP(a_empty_ready, clock, reset, !rsp_valid, !req_stall, "input stalled with empty result queue")

endmodule

bind seq_window_ack_beacon_gateway swab_checker u_swab_checker (.*);
